FILE: rtl/ipd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the +IPD frame deframer
// Character codes of the frame header, length field limits and the
// result record passed from the parser to the output register.
// ----------------------------------------------------------------------------
package ipd_pkg;

	localparam int unsigned ACC_W      = 17;
	localparam int unsigned HCNT_W     = 3;
	localparam int unsigned DCNT_W     = 3;
	localparam int unsigned CFG_W      = 11;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_I     = 8'h49;
	localparam logic [7:0] CHAR_P     = 8'h50;
	localparam logic [7:0] CHAR_D     = 8'h44;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [HCNT_W-1:0] HDR_LEN    = 3'd5;
	localparam logic [DCNT_W-1:0] MAX_DIGITS = 3'd5;

	localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 11'd1000;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       frame_end;
		logic       length_error;
	} result_t;

	// Expected header character at a given position of "+IPD,".
	function automatic logic [7:0] hdr_char(input logic [HCNT_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = CHAR_PLUS;
			3'd1: c = CHAR_I;
			3'd2: c = CHAR_P;
			3'd3: c = CHAR_D;
			3'd4: c = CHAR_COMMA;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ipd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_parser: frame state machine
// Holds the parse state and computes, for the byte in the input register,
// the next state and the result (if any) in one pass.
// ----------------------------------------------------------------------------
module ipd_parser #(
	parameter int unsigned BUFFER_BYTES = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [7:0]                  rx_b,
	input  wire logic [ipd_pkg::CFG_W-1:0]   max_payload,
	output ipd_pkg::result_t                 res
);
	import ipd_pkg::*;

	localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
	localparam int unsigned LIM_CAP = (BUFFER_BYTES < CFG_MAX) ? BUFFER_BYTES : CFG_MAX;
	localparam int unsigned REM_W   = $clog2(LIM_CAP + 1);
	localparam logic [ACC_W-1:0] BUF_LIM = ACC_W'(BUFFER_BYTES);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_LENGTH  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [HCNT_W-1:0] hcnt_q, hcnt_d;
	logic [DCNT_W-1:0] dcnt_q, dcnt_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [REM_W-1:0]  rem_q, rem_d;

	logic              is_digit;
	logic              is_plus;
	logic [ACC_W-1:0]  acc_times10;
	logic [ACC_W-1:0]  limit;
	logic [ACC_W-1:0]  max_ext;

	assign is_digit    = (rx_b >= CHAR_ZERO) && (rx_b <= CHAR_NINE);
	assign is_plus     = (rx_b == CHAR_PLUS);
	assign acc_times10 = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};
	assign max_ext     = {{(ACC_W-CFG_W){1'b0}}, max_payload};
	assign limit       = (max_ext > BUF_LIM) ? BUF_LIM : max_ext;

	always_comb begin
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		dcnt_d  = dcnt_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		res     = '0;

		case (phase_q)
			PH_HUNT: begin
				phase_d = is_plus ? PH_HEADER : PH_HUNT;
				hcnt_d  = is_plus ? 3'd1 : 3'd0;
				dcnt_d  = '0;
				acc_d   = '0;
				rem_d   = '0;
			end
			PH_HEADER: begin
				if (hcnt_q < HDR_LEN && rx_b == hdr_char(hcnt_q)) begin
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_q + 3'd1 == HDR_LEN) begin
						phase_d = PH_LENGTH;
						dcnt_d  = '0;
						acc_d   = '0;
					end
				end else begin
					// A mismatching '+' may itself open a new header.
					phase_d = is_plus ? PH_HEADER : PH_HUNT;
					hcnt_d  = is_plus ? 3'd1 : 3'd0;
					dcnt_d  = '0;
					acc_d   = '0;
					rem_d   = '0;
				end
			end
			PH_LENGTH: begin
				if (is_digit && dcnt_q < MAX_DIGITS) begin
					acc_d  = acc_times10 + {{(ACC_W-4){1'b0}}, 4'(rx_b - CHAR_ZERO)};
					dcnt_d = dcnt_q + 3'd1;
				end else if (rx_b == CHAR_COLON && acc_q != '0 && acc_q <= limit) begin
					phase_d = PH_PAYLOAD;
					rem_d   = acc_q[REM_W-1:0];
				end else begin
					// Sixth digit, bad character, zero length or oversize length.
					phase_d = is_plus ? PH_HEADER : PH_HUNT;
					hcnt_d  = is_plus ? 3'd1 : 3'd0;
					dcnt_d  = '0;
					acc_d   = '0;
					rem_d   = '0;
					if (rx_b == CHAR_COLON && acc_q > limit) begin
						res.valid        = 1'b1;
						res.length_error = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				res.valid        = 1'b1;
				res.payload_byte = rx_b;
				if (rem_q <= REM_W'(1)) begin
					res.frame_end = 1'b1;
					phase_d       = PH_HUNT;
					hcnt_d        = '0;
					dcnt_d        = '0;
					acc_d         = '0;
					rem_d         = '0;
				end else begin
					rem_d = rem_q - REM_W'(1);
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hcnt_q  <= '0;
			dcnt_q  <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			dcnt_q  <= dcnt_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ipd_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_frame_deframer: +IPD frame payload extractor
// Parses "+IPD,<len>:<data>" from a received byte stream and forwards the
// payload bytes, flagging the last one, or reports an oversize length.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    rx_byte
//   out       output     out_valid/out_ready  payload_byte, frame_end,
//                                             length_error
//   cfg       input      cfg_wr_en            cfg_wr_data (max_payload)
//
// One byte per cycle is sustained while out_ready is held high: each byte
// waits in the input register while the state machine evaluates it, and its
// result is loaded into the output register on the edge that steps the parser.
// A stalled output register holds the input register, and in_ready drops
// only while both are full. Reset clears all control state and sets
// max_payload to 1000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipd_frame_deframer #(
	parameter int unsigned BUFFER_BYTES = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [7:0]                  rx_byte,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [7:0]                  payload_byte,
	output      logic                        frame_end,
	output      logic                        length_error,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ipd_pkg::CFG_W-1:0]   cfg_wr_data
);
	import ipd_pkg::*;

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             out_valid_q;
	logic [7:0]       payload_byte_q;
	logic             frame_end_q;
	logic             length_error_q;
	logic [CFG_W-1:0] max_payload_q;
	logic             advance;
	result_t          res;

	// The byte in the input register moves on whenever the output slot is free
	// or is being emptied this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			max_payload_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ipd_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_b        (rx_byte_s1),
		.max_payload (max_payload_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			payload_byte_q <= res.payload_byte;
			frame_end_q    <= res.frame_end;
			length_error_q <= res.length_error;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_byte_q;
	assign frame_end    = frame_end_q;
	assign length_error = length_error_q;

`ifndef SYNTH
	// An error transaction never closes a frame and never carries data.
	a_err_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> !frame_end && payload_byte == 8'h00)
		else $error("length error result with frame_end or data");

	// With the output register empty, the input side must never stall.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while output register empty");

	// A byte held in the input register while the output stalls stays put.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |=> valid_s1 && $stable(rx_byte_s1))
		else $error("input register lost a byte during output stall");
`endif

endmodule
`default_nettype wire
